// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file gdp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define GDP_ASSERT_NOW(label, cond, rhs, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (rhs)) else $error(msg);

// Implication checked in the next cycle.
`define GDP_ASSERT_NEXT(label, cond, rhs, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (rhs)) else $error(msg);

`endif

// ----- sv/gdp_pkg.sv -----
`timescale 1ns / 1ps
package gdp_pkg;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int DIM_W      = 7;
    localparam int COST_BITS  = 24;
    localparam int STEP_W     = 16;

    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    // Item kinds
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_PLAN = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_EDGE   = 2'd2;
    localparam logic [1:0] CFG_DIAG   = 2'd3;

    // One entry of the search memory
    typedef struct packed {
        logic                 open_m;
        logic                 closed_m;
        logic [COST_BITS-1:0] cost;
        logic [ADDR_W-1:0]    parent;
    } t_node;

    localparam int NODE_W = $bits(t_node);
endpackage

// ----- sv/gdp_ram.sv -----
`timescale 1ns / 1ps
module gdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

// ----- sv/grid_dijkstra_planner.sv -----
`timescale 1ns / 1ps
// Load and unused-kind items go to the final state; a read first reads the path memory.
// Plan: clear all 4096 cells, init, then per expanded cell a scan of all
// n = width*height cells, a select step, read and evaluate per in-grid neighbor
// and a read only per off-grid one; the path is then walked back and stored.
// One transaction at a time: ready again in the cycle after the result is registered.
// Reset (synchronous, active low): config 64/64/1000/1414, found 0, length 0, idle.
module grid_dijkstra_planner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] cell_index, [19:12] cell_value, [31:20] start_cell,
    // [43:32] goal_cell, [55:44] path_position
    input  logic [55:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [12:0] path_length, [24:13] path_cell, [31:25] zero
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser    // [0] found
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIN  = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_INIT = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_SEL  = 4'd6;
    localparam logic [3:0] S_NRD  = 4'd7;
    localparam logic [3:0] S_NEV  = 4'd8;
    localparam logic [3:0] S_WLK  = 4'd9;
    localparam logic [3:0] S_WLKD = 4'd10;
    localparam logic [3:0] S_WR   = 4'd11;
    localparam logic [3:0] S_WRD  = 4'd12;

    localparam int AW = gdp_pkg::ADDR_W;
    localparam int LW = gdp_pkg::LEN_W;
    localparam int DW = gdp_pkg::DIM_W;
    localparam int CW = gdp_pkg::COST_BITS;

    logic [3:0]     r_state, n_state;
    logic [DW-1:0]  r_w, r_h;
    logic [15:0]    r_edge, r_diag;
    logic [DW-1:0]  r_gw, r_gh;
    logic [LW-1:0]  r_n;
    logic [AW-1:0]  r_start, r_goal, r_pos;
    logic           r_found;
    logic [LW-1:0]  r_len;
    logic [AW-1:0]  r_cell;
    logic [LW-1:0]  r_cnt;
    // scan issue and evaluate stages
    logic [LW-1:0]  r_si;
    logic [DW-1:0]  r_sr, r_sc;
    logic           r_pv;
    logic [AW-1:0]  r_pi;
    logic [DW-1:0]  r_pr, r_pc;
    // best open cell of the current scan
    logic           r_have;
    logic [AW-1:0]  r_cur;
    logic [DW-1:0]  r_cr, r_cc;
    logic [CW-1:0]  r_cmin;
    logic [AW-1:0]  r_cpar;
    // neighbor loop and path walk
    logic [2:0]     r_k;
    logic [AW-1:0]  r_nb;
    logic           r_ndiag;
    logic [AW-1:0]  r_node;
    // output register
    logic           r_ovalid, r_o_found;
    logic [LW-1:0]  r_o_len;
    logic [AW-1:0]  r_o_cell;

    logic           in_fire, out_fire, push_ok;
    logic [1:0]     in_action;
    logic [AW-1:0]  in_cell_index, in_start, in_goal, in_pos;
    logic [7:0]     in_cell_value;
    logic [DW-1:0]  clamp_w, clamp_h;

    // memory ports
    gdp_pkg::t_node node_wdata, node_q;
    logic           node_we, node_re;
    logic [AW-1:0]  node_waddr, node_raddr;
    logic           free_we, free_re, free_q;
    logic [AW-1:0]  free_addr;
    logic           path_we, path_re;
    logic [AW-1:0]  path_waddr, path_raddr, path_q;

    // neighbor geometry
    logic           rn, rp, cn, cp, inb, diag;
    logic [LW-1:0]  nb_full;
    logic [CW:0]    g_sum;
    logic [CW-1:0]  g_cost;
    logic           relax, walk_more, scan_issue, scan_better;

    assign in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire      = r_ovalid && i_m_axis_tready;
    assign push_ok       = !r_ovalid || i_m_axis_tready;
    assign in_action     = i_s_axis_tuser;
    assign in_cell_index = i_s_axis_tdata[11:0];
    assign in_cell_value = i_s_axis_tdata[19:12];
    assign in_start      = i_s_axis_tdata[31:20];
    assign in_goal       = i_s_axis_tdata[43:32];
    assign in_pos        = i_s_axis_tdata[55:44];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_o_found;
    assign o_m_axis_tdata  = {7'd0, r_o_cell, r_o_len};

    // Grid size as used by a plan
    always_comb begin
        if (r_w == '0) begin
            clamp_w = DW'(1);
        end else if (r_w > DW'(gdp_pkg::MAX_WIDTH)) begin
            clamp_w = DW'(gdp_pkg::MAX_WIDTH);
        end else begin
            clamp_w = r_w;
        end
        if (r_h == '0) begin
            clamp_h = DW'(1);
        end else if (r_h > DW'(gdp_pkg::MAX_HEIGHT)) begin
            clamp_h = DW'(gdp_pkg::MAX_HEIGHT);
        end else begin
            clamp_h = r_h;
        end
    end

    // Neighbor direction from the loop counter: row minus/plus, column minus/plus
    always_comb begin
        case (r_k)
            3'd0:    {rn, rp, cn, cp} = 4'b1010;
            3'd1:    {rn, rp, cn, cp} = 4'b1000;
            3'd2:    {rn, rp, cn, cp} = 4'b1001;
            3'd3:    {rn, rp, cn, cp} = 4'b0010;
            3'd4:    {rn, rp, cn, cp} = 4'b0001;
            3'd5:    {rn, rp, cn, cp} = 4'b0110;
            3'd6:    {rn, rp, cn, cp} = 4'b0100;
            default: {rn, rp, cn, cp} = 4'b0101;
        endcase
    end

    assign inb = !(rn && (r_cr == '0)) && !(rp && ((r_cr + DW'(1)) >= r_gh))
              && !(cn && (r_cc == '0)) && !(cp && ((r_cc + DW'(1)) >= r_gw));
    assign diag = (rn || rp) && (cn || cp);

    // Neighbor index: rows move by the width, columns by one
    always_comb begin
        nb_full = {1'b0, r_cur};
        if (rn) nb_full = nb_full - LW'(r_gw);
        if (rp) nb_full = nb_full + LW'(r_gw);
        if (cn) nb_full = nb_full - LW'(1);
        if (cp) nb_full = nb_full + LW'(1);
    end

    // Saturating tentative cost
    assign g_sum  = {1'b0, r_cmin} + (CW+1)'(r_ndiag ? r_diag : r_edge);
    assign g_cost = g_sum[CW] ? gdp_pkg::COST_MAX : g_sum[CW-1:0];
    assign relax  = free_q && !node_q.closed_m && (!node_q.open_m || (g_cost < node_q.cost));

    assign walk_more   = (r_node != r_start) && (r_cnt < r_n);
    assign scan_issue  = (r_si < r_n);
    assign scan_better = r_pv && node_q.open_m && !node_q.closed_m
                      && (!r_have || (node_q.cost < r_cmin));

    // Search memory port control
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_cnt[AW-1:0];
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = r_node;
        case (r_state)
            S_CLR: begin
                node_we = 1'b1;
            end
            S_INIT: begin
                node_we    = 1'b1;
                node_waddr = r_start;
                node_wdata = '{open_m: 1'b1, closed_m: 1'b0, cost: '0, parent: r_start};
            end
            S_SCAN: begin
                node_re    = scan_issue;
                node_raddr = r_si[AW-1:0];
            end
            S_SEL: begin
                node_we    = r_have;
                node_waddr = r_cur;
                node_wdata = '{open_m: 1'b1, closed_m: 1'b1, cost: r_cmin, parent: r_cpar};
            end
            S_NRD: begin
                node_re    = inb;
                node_raddr = nb_full[AW-1:0];
            end
            S_NEV: begin
                node_we    = relax;
                node_waddr = r_nb;
                node_wdata = '{open_m: 1'b1, closed_m: 1'b0, cost: g_cost, parent: r_cur};
            end
            S_WLK: begin
                node_re = 1'b1;
            end
            S_WR: begin
                node_re = 1'b1;
            end
            default: begin
                node_re = 1'b0;
            end
        endcase
    end

    // Occupancy and path memory control
    assign free_we    = in_fire && (in_action == gdp_pkg::ACT_LOAD);
    assign free_re    = (r_state == S_NRD) && inb;
    assign free_addr  = free_we ? in_cell_index : nb_full[AW-1:0];
    assign path_we    = (r_state == S_WR) && (r_cnt != '0);
    assign path_waddr = AW'(r_cnt - LW'(1));
    assign path_re    = in_fire && (in_action == gdp_pkg::ACT_READ);
    assign path_raddr = in_pos;

    gdp_ram #(.WIDTH(gdp_pkg::NODE_W), .DEPTH(gdp_pkg::CELLS)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (node_we),
        .i_wr_addr (node_waddr),
        .i_wr_data (node_wdata),
        .i_rd_en   (node_re),
        .i_rd_addr (node_raddr),
        .o_rd_data (node_q)
    );

    gdp_ram #(.WIDTH(1), .DEPTH(gdp_pkg::CELLS)) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (free_we),
        .i_wr_addr (free_addr),
        .i_wr_data (in_cell_value == 8'd0),
        .i_rd_en   (free_re),
        .i_rd_addr (free_addr),
        .o_rd_data (free_q)
    );

    gdp_ram #(.WIDTH(AW), .DEPTH(gdp_pkg::CELLS)) u_path_ram (
        .i_clk     (i_clk),
        .i_wr_en   (path_we),
        .i_wr_addr (path_waddr),
        .i_wr_data (r_node),
        .i_rd_en   (path_re),
        .i_rd_addr (path_raddr),
        .o_rd_data (path_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_action)
                        gdp_pkg::ACT_PLAN: n_state = S_CLR;
                        gdp_pkg::ACT_READ: n_state = S_PRD;
                        default:           n_state = S_FIN;
                    endcase
                end
            end
            S_FIN:  if (push_ok) n_state = S_IDLE;
            S_PRD:  n_state = S_FIN;
            S_CLR:  if (r_cnt == LW'(gdp_pkg::CELLS - 1)) n_state = S_INIT;
            S_INIT: begin
                if (({1'b0, r_start} >= r_n) || ({1'b0, r_goal} >= r_n)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: if (!scan_issue && !r_pv) n_state = S_SEL;
            S_SEL: begin
                if (!r_have) begin
                    n_state = S_FIN;
                end else if (r_cur == r_goal) begin
                    n_state = S_WLK;
                end else begin
                    n_state = S_NRD;
                end
            end
            S_NRD: begin
                if (inb) begin
                    n_state = S_NEV;
                end else if (r_k == 3'd7) begin
                    n_state = S_SCAN;
                end
            end
            S_NEV:  n_state = (r_k == 3'd7) ? S_SCAN : S_NRD;
            S_WLK:  n_state = walk_more ? S_WLKD : S_WR;
            S_WLKD: n_state = S_WLK;
            S_WR:   n_state = (r_cnt != '0) ? S_WRD : S_FIN;
            S_WRD:  n_state = S_WR;
            default: n_state = S_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_w      <= DW'(64);
            r_h      <= DW'(64);
            r_edge   <= 16'd1000;
            r_diag   <= 16'd1414;
            r_found  <= 1'b0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            // config write transaction
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gdp_pkg::CFG_WIDTH:  r_w    <= i_cfg_data[DW-1:0];
                    gdp_pkg::CFG_HEIGHT: r_h    <= i_cfg_data[DW-1:0];
                    gdp_pkg::CFG_EDGE:   r_edge <= i_cfg_data;
                    default:             r_diag <= i_cfg_data;
                endcase
            end

            // result taken; the final state reloads it in the same cycle
            if (out_fire && (r_state != S_FIN)) r_ovalid <= 1'b0;

            // scan restart on every entry into the scan
            if ((n_state == S_SCAN) && (r_state != S_SCAN)) begin
                r_si   <= '0;
                r_sr   <= '0;
                r_sc   <= '0;
                r_pv   <= 1'b0;
                r_have <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cell  <= '0;
                        r_pos   <= in_pos;
                        r_start <= in_start;
                        r_goal  <= in_goal;
                        if (in_action == gdp_pkg::ACT_PLAN) begin
                            r_gw    <= clamp_w;
                            r_gh    <= clamp_h;
                            r_found <= 1'b0;
                            r_len   <= '0;
                            r_cnt   <= '0;
                        end
                    end
                end
                S_FIN: begin
                    if (push_ok) begin
                        r_ovalid  <= 1'b1;
                        r_o_found <= r_found;
                        r_o_len   <= r_len;
                        r_o_cell  <= r_cell;
                    end
                end
                S_PRD: begin
                    r_cell <= ({1'b0, r_pos} < r_len) ? path_q : '0;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + LW'(1);
                    r_n   <= LW'({{(LW-DW){1'b0}}, r_gw} * {{(LW-DW){1'b0}}, r_gh});
                end
                S_SCAN: begin
                    // issue stage
                    if (scan_issue) begin
                        r_pv <= 1'b1;
                        r_pi <= r_si[AW-1:0];
                        r_pr <= r_sr;
                        r_pc <= r_sc;
                        r_si <= r_si + LW'(1);
                        if ((r_sc + DW'(1)) == r_gw) begin
                            r_sc <= '0;
                            r_sr <= r_sr + DW'(1);
                        end else begin
                            r_sc <= r_sc + DW'(1);
                        end
                    end else begin
                        r_pv <= 1'b0;
                    end
                    // evaluate stage: strict compare keeps the lowest index on ties
                    if (scan_better) begin
                        r_have <= 1'b1;
                        r_cur  <= r_pi;
                        r_cr   <= r_pr;
                        r_cc   <= r_pc;
                        r_cmin <= node_q.cost;
                        r_cpar <= node_q.parent;
                    end
                end
                S_SEL: begin
                    r_k    <= '0;
                    r_node <= r_goal;
                    r_cnt  <= LW'(1);
                end
                S_NRD: begin
                    r_nb    <= nb_full[AW-1:0];
                    r_ndiag <= diag;
                    if (!inb) r_k <= r_k + 3'd1;
                end
                S_NEV: begin
                    r_k <= r_k + 3'd1;
                end
                S_WLK: begin
                    if (!walk_more) begin
                        r_len  <= r_cnt;
                        r_node <= r_goal;
                    end
                end
                S_WLKD: begin
                    r_node <= node_q.parent;
                    r_cnt  <= r_cnt + LW'(1);
                end
                S_WR: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - LW'(1);
                    end else begin
                        r_found <= 1'b1;
                    end
                end
                S_WRD: begin
                    r_node <= node_q.parent;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end
endmodule

// ----- sv/gdp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    // result stays offered until taken
    `GDP_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped")
    // no path length without a found path
    `GDP_ASSERT_NOW(a_len_nf, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[12:0] == 13'd0, "length without found")
    // a found path holds at least the start cell
    `GDP_ASSERT_NOW(a_len_f, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[12:0] != 13'd0, "found with empty path")
    // a nonzero path cell only comes from a found path
    `GDP_ASSERT_NOW(a_cell, o_m_axis_tvalid && (o_m_axis_tdata[24:13] != 12'd0), o_m_axis_tuser, "cell without path")
    // padding bits stay zero
    `GDP_ASSERT_NOW(a_pad, o_m_axis_tvalid, o_m_axis_tdata[31:25] == 7'd0, "padding not zero")
endmodule

bind grid_dijkstra_planner gdp_checker u_gdp_checker (.*);

// ----- tb/sv/gdp_path_checker.sv -----
`timescale 1ns / 1ps
module gdp_path_checker
    import gdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [55:0] i_in_data,
    input  logic [1:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_user,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] path_cell;
    } t_status;

    t_status status_q[$];

    // predictor copy of the registers and memories
    logic [DIM_W-1:0]     grid_w, grid_h;
    logic [STEP_W-1:0]    edge_step, diag_step;
    bit                   free_map[CELLS];
    logic [COST_BITS-1:0] best[CELLS];
    logic [ADDR_W-1:0]    parent_of[CELLS];
    bit                   closed_m[CELLS];
    bit                   open_m[CELLS];
    logic [ADDR_W-1:0]    path_mem[CELLS];
    logic [LEN_W-1:0]     plen;
    bit                   pfound;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report(input string what, input int exp_v, input int got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        o_errors++;
    endtask

    // Dijkstra over the 8-connected grid, smallest index wins on equal cost
    task automatic run_search(input int src, input int dst);
        int w, h, n, cur, i, nb, len, node, k, r, c, dr, dc, nr, nc;
        logic [COST_BITS-1:0] cmin, gcost;
        logic [COST_BITS:0]   sum;
        bit reached, have;
        w = (grid_w == 0) ? 1 : ((grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w));
        h = (grid_h == 0) ? 1 : ((grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h));
        n = w * h;
        reached = 0;
        for (i = 0; i < CELLS; i++) begin
            closed_m[i] = 0;
            open_m[i]   = 0;
        end
        plen   = '0;
        pfound = 0;
        if (src >= n || dst >= n) return;
        open_m[src]    = 1;
        best[src]      = '0;
        parent_of[src] = src[ADDR_W-1:0];
        forever begin
            have = 0;
            cmin = '0;
            cur  = 0;
            for (i = 0; i < n; i++) begin
                if (open_m[i] && !closed_m[i] && (!have || best[i] < cmin)) begin
                    have = 1;
                    cur  = i;
                    cmin = best[i];
                end
            end
            if (!have) break;
            closed_m[cur] = 1;
            if (cur == dst) begin
                reached = 1;
                break;
            end
            r = cur / w;
            c = cur % w;
            for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                    nr = r + dr;
                    nc = c + dc;
                    if (dr == 0 && dc == 0) continue;
                    if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
                    nb = nr * w + nc;
                    if (!free_map[nb] || closed_m[nb]) continue;
                    sum = {1'b0, cmin} + ((dr != 0 && dc != 0) ? diag_step : edge_step);
                    gcost = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
                    if (!open_m[nb] || gcost < best[nb]) begin
                        open_m[nb]    = 1;
                        best[nb]      = gcost;
                        parent_of[nb] = cur[ADDR_W-1:0];
                    end
                end
            end
        end
        if (!reached) return;
        // walk parents back to the start, then store the path forward
        len  = 1;
        node = dst;
        while (node != src && len < n) begin
            node = parent_of[node];
            len++;
        end
        node = dst;
        for (k = len; k > 0; k--) begin
            path_mem[k-1] = node[ADDR_W-1:0];
            node = parent_of[node];
        end
        plen   = len[LEN_W-1:0];
        pfound = 1;
    endtask

    always @(posedge i_clk) begin
        t_status got, exp_s;
        int pos;
        if (!i_rst_n) begin
            grid_w    = 7'd64;
            grid_h    = 7'd64;
            edge_step = 16'd1000;
            diag_step = 16'd1414;
            plen      = '0;
            pfound    = 0;
            status_q.delete();
        end else begin
            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  grid_w    = i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: grid_h    = i_cfg_data[DIM_W-1:0];
                    CFG_EDGE:   edge_step = i_cfg_data;
                    CFG_DIAG:   diag_step = i_cfg_data;
                    default: ;
                endcase
            end
            // input transaction: predict its status
            if (i_in_valid && i_in_ready) begin
                exp_s = '0;
                case (i_in_user)
                    ACT_LOAD: free_map[i_in_data[11:0]] = (i_in_data[19:12] == 0);
                    ACT_PLAN: run_search(i_in_data[31:20], i_in_data[43:32]);
                    ACT_READ: begin
                        pos = i_in_data[55:44];
                        if (pos < plen) exp_s.path_cell = path_mem[pos];
                    end
                    default: ;
                endcase
                exp_s.found = pfound;
                exp_s.len   = plen;
                status_q.insert(status_q.size(), exp_s);
            end
            // output transaction: compare with oldest expectation
            if (i_out_valid && i_out_ready) begin
                got.found     = i_out_user;
                got.len       = i_out_data[12:0];
                got.path_cell = i_out_data[24:13];
                if (status_q.size() == 0) begin
                    report("unexpected result", 0, 1);
                end else begin
                    exp_s = status_q.pop_front();
                    if (got.found !== exp_s.found) report("found", exp_s.found, got.found);
                    if (got.len !== exp_s.len) report("path_length", exp_s.len, got.len);
                    if (got.path_cell !== exp_s.path_cell)
                        report("path_cell", exp_s.path_cell, got.path_cell);
                end
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ----- tb/sv/tb_grid_dijkstra_planner.sv -----
`timescale 1ns / 1ps
module tb_grid_dijkstra_planner;
    import gdp_pkg::*;

    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_valid = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 0;
    logic [55:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 0;
    logic        o_cfg_ready, o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tuser;
    logic [31:0] o_m_axis_tdata;
    int          errors, pending;

    int send_idle = 0, recv_idle = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int stall_cnt = 0;
    int cur_n = 4096;
    bit loaded[CELLS];

    always #5 i_clk = ~i_clk;

    grid_dijkstra_planner i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    gdp_path_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(s_valid), .i_in_ready(o_s_axis_tready),
        .i_in_data(s_data), .i_in_user(s_user),
        .i_out_valid(o_m_axis_tvalid), .i_out_ready(m_ready),
        .i_out_data(o_m_axis_tdata), .i_out_user(o_m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // one input transaction; returns right after the accepting edge
    task automatic send_item(input logic [1:0] act, input int idx, input int val,
                             input int st, input int gl, input int pos);
        logic [55:0] d;
        d = {pos[11:0], gl[11:0], st[11:0], val[7:0], idx[11:0]};
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_user  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (act == ACT_LOAD) loaded[idx[11:0]] = 1;
    endtask

    task automatic load(input int idx, input int val);
        send_item(ACT_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic plan(input int st, input int gl);
        send_item(ACT_PLAN, $urandom, $urandom, st, gl, $urandom);
    endtask

    task automatic read_pos(input int pos);
        send_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, pos);
    endtask

    function automatic int rand_value();
        return ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 255);
    endfunction

    // register write, only once every expected result has come back
    task automatic write_reg(input logic [1:0] idx, input int val);
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // set all registers and make sure every cell in use has been loaded
    task automatic setup(input int w, input int h, input int e, input int dg);
        int cw, ch;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_EDGE, e);
        write_reg(CFG_DIAG, dg);
        cw = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        ch = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        cur_n = cw * ch;
        for (int i = 0; i < cur_n; i++)
            if (!loaded[i]) load(i, rand_value());
    endtask

    function automatic int rand_step();
        case ($urandom_range(5))
            0: return 1;
            1: return 65535;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // mix of loads, plans, path reads and unused-kind items on the current grid
    task automatic random_items(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 40)      load($urandom_range(0, cur_n - 1), rand_value());
            else if (r < 48) load($urandom_range(0, CELLS - 1), rand_value());
            else if (r < 58) plan($urandom_range(0, cur_n - 1), $urandom_range(0, cur_n - 1));
            else if (r < 60) plan($urandom_range(0, 4095), $urandom_range(0, 4095));
            else if (r < 94) read_pos($urandom_range(0, cur_n + 1));
            else if (r < 97) read_pos($urandom_range(0, 4095));
            else send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input bit squeeze);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(4) == 0)
                setup(64, 1, rand_step(), rand_step());
            else
                setup($urandom_range(1, 6), $urandom_range(1, 6), rand_step(), rand_step());
            // long receiver hold while the sender keeps offering
            if (squeeze && k == 0) begin
                hold_req = 1;
                for (int j = 0; j < 40; j++)
                    load($urandom_range(0, cur_n - 1), rand_value());
            end
            random_items(75);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: 4x4 grid with a wall, corner cells and all item kinds
        load(4095, 0);
        load(4094, 255);
        setup(4, 4, 1000, 1414);
        load(5, 255);
        load(6, 1);
        load(9, 128);
        plan(0, 15);
        read_pos(0);
        read_pos(1);
        read_pos(4095);
        plan(4095, 0);          // start outside the grid
        plan(0, 16);            // goal outside the grid
        plan(5, 0);             // blocked start
        plan(6, 6);             // blocked goal equal to start
        plan(0, 9);             // blocked goal elsewhere
        read_pos(0);
        send_item(2'd3, 0, 0, 0, 0, 0);
        plan(3, 3);
        read_pos(0);

        // extremes of the grid size and step costs; the full grid plan
        // starts on its goal, so only that loaded corner cell is visited
        write_reg(CFG_WIDTH, 64);
        write_reg(CFG_HEIGHT, 64);
        write_reg(CFG_EDGE, 1);
        write_reg(CFG_DIAG, 65535);
        plan(4095, 4095);
        read_pos(0);
        setup(0, 0, 65535, 1);
        plan(0, 0);
        setup(127, 1, 1, 1);
        plan(0, 63);
        read_pos(62);
        setup(1, 64, 65535, 65535);
        plan(0, 63);
        read_pos(63);

        random_phase(15, 80, 0);
        random_phase(80, 15, 0);
        random_phase(0, 0, 1);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- grid_dijkstra_planner.f -----
+incdir+sv
sv/gdp_pkg.sv
sv/gdp_ram.sv
sv/grid_dijkstra_planner.sv
sv/gdp_checker.sv
tb/sv/gdp_path_checker.sv
tb/sv/tb_grid_dijkstra_planner.sv
